FILE: hw/rtl/fsu_pkg.sv
// ----------------------------------------------------------------------------
// fsu_pkg
// Shared widths and types of the floor sum unit: operand, product, dividend
// and accumulator sizes, and the request bundle of the iterative divider.
// ----------------------------------------------------------------------------
package fsu_pkg;

  // Width of slope, divisor and count; the offset carries one more bit.
  localparam int unsigned OPERAND_WIDTH = 20;
  localparam int unsigned OW = OPERAND_WIDTH;

  // Result width of the sum.
  localparam int unsigned ACC_W = 64;

  // Multiplier operands are one bit wider than the operands.
  localparam int unsigned MUL_W  = OW + 1;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Long dividend: a product of two operands plus an operand.
  localparam int unsigned DVD_W = 2 * OW + 1;
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  // Triangular number n*(n-1)/2 needs one bit less than the square.
  localparam int unsigned TRI_W = 2 * OW - 1;

  // Scratch width large enough for a shifted product and the accumulator.
  localparam int unsigned WIDE_W = (PROD_W + OW > ACC_W) ? (PROD_W + OW) : ACC_W;

  // Request bundle from the sequencer to the divider.
  typedef struct packed {
    logic start;
    logic long_op;
  } div_req_t;

endpackage

FILE: hw/rtl/fsu_div.sv
// ----------------------------------------------------------------------------
// fsu_div
// Iterative restoring divider, one quotient bit per cycle. A short request
// divides an operand of OW+1 bits; a long request divides a full DVD_W-bit
// dividend. done_o pulses when the result holds.
// ----------------------------------------------------------------------------
module fsu_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fsu_pkg::div_req_t           req_i,
  input  logic [fsu_pkg::DVD_W-1:0]   dividend_i,
  input  logic [fsu_pkg::OW-1:0]      divisor_i,
  output logic                        done_o,
  output logic [fsu_pkg::DVD_W-1:0]   quot_o,
  output logic [fsu_pkg::OW-1:0]      rem_o
);
  import fsu_pkg::*;

  logic [DVD_W-1:0] dvd_q;
  logic [DVD_W-1:0] quo_q;
  logic [OW:0]      rem_q;
  logic [OW-1:0]    den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [OW:0]      rem_sh;
  logic [OW:0]      rem_diff;
  logic             fits;

  // One restoring step: bring in the next dividend bit and try a subtraction.
  always_comb begin
    rem_sh   = {rem_q[OW-1:0], dvd_q[DVD_W-1]};
    fits     = (rem_sh >= {1'b0, den_q});
    rem_diff = rem_sh - {1'b0, den_q};
  end

  // Control and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.long_op ? CNT_W'(DVD_W) : CNT_W'(OW + 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      // A short operand is moved to the top so that only its bits are scanned.
      dvd_q <= req_i.long_op ? dividend_i
                             : {dividend_i[OW:0], {(DVD_W - OW - 1){1'b0}}};
      quo_q <= '0;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[DVD_W-2:0], fits};
      rem_q <= fits ? rem_diff : rem_sh;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q[OW-1:0];

endmodule

FILE: hw/rtl/fsu_mul.sv
// ----------------------------------------------------------------------------
// fsu_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module fsu_mul (
  input  logic                        clk_i,
  input  logic [fsu_pkg::MUL_W-1:0]   x_i,
  input  logic [fsu_pkg::MUL_W-1:0]   y_i,
  output logic [fsu_pkg::PROD_W-1:0]  prod_o
);
  import fsu_pkg::*;

  logic [PROD_W-1:0] prod_q;

  // Full-width product, registered before any further use.
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(x_i) * PROD_W'(y_i);
  end

  assign prod_o = prod_q;

endmodule

FILE: hw/rtl/floor_sum_unit.sv
// ----------------------------------------------------------------------------
// floor_sum_unit
// Sum of floor((slope*i + offset) / divisor) over i = 0 .. count-1, by the
// Euclid-like reduction on a shared divider and a shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (slope_i, offset_i, divisor_i, count_i) is taken when
//   in_valid_i is high and in_stall_o is low. The unit then works on that one
//   request and holds in_stall_o high until the sum is placed in the output
//   register. The result beat total_o is delivered when out_valid_o is high
//   and out_stall_i is low; a new request may be taken while it waits.
//   Each reduction level runs two short divisions of OW+1 bits, one long
//   division of 2*OW+1 bits and further issue, multiply and accumulate
//   steps. The number of levels follows the Euclidean chain of slope and
//   divisor, at most about thirty at 20 bits.
//   A zero count or a zero divisor gives a total of zero.
//   Reset clears the sequencer and the output valid flag; no other state is
//   kept between requests. While the receiver stalls, a finished sum waits
//   in the sequencer until the output register is free.
// ----------------------------------------------------------------------------
module floor_sum_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic        [fsu_pkg::OW-1:0]     slope_i,
  input  logic signed [fsu_pkg::OW:0]       offset_i,
  input  logic        [fsu_pkg::OW-1:0]     divisor_i,
  input  logic        [fsu_pkg::OW-1:0]     count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [fsu_pkg::ACC_W-1:0]  total_o
);
  import fsu_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DIVA, S_WDIVA, S_TRI, S_TRIR, S_TLO, S_TLOR, S_THI, S_THIR,
    S_DIVB, S_WDIVB, S_NB, S_NBR, S_TOPM, S_TOPD, S_WTOP, S_TN, S_TNR,
    S_SWAP, S_DONE
  } state_e;

  state_e            state_q;
  logic [OW-1:0]     a_q;
  logic [OW:0]       b_q;
  logic [OW-1:0]     m_q;
  logic [OW-1:0]     n_q;
  logic [OW-1:0]     q_q;
  logic [TRI_W-1:0]  tri_q;
  logic [OW:0]       qb_q;
  logic              bneg_q;
  logic [OW-1:0]     top_q;
  logic              neg_q;
  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  acc_d;
  logic [ACC_W-1:0]  out_q;
  logic              out_valid_q;

  div_req_t          div_req;
  logic [DVD_W-1:0]  div_dvd;
  logic              div_done;
  logic [DVD_W-1:0]  div_quot;
  logic [OW-1:0]     div_rem;

  logic [MUL_W-1:0]  mul_x;
  logic [MUL_W-1:0]  mul_y;
  logic [PROD_W-1:0] prod;

  logic [OW:0]       b_mag;
  logic [ACC_W-1:0]  addend;
  logic              sub;
  logic [WIDE_W-1:0] wide;
  logic              in_beat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;

  // Magnitude of the offset; only the first level can see a negative one.
  assign b_mag = b_q[OW] ? (~b_q + (OW+1)'(1)) : b_q;

  // Divider requests and dividend selection.
  always_comb begin
    div_req = '0;
    div_dvd = '0;
    unique case (state_q)
      S_DIVA: begin
        div_req.start = 1'b1;
        div_dvd       = DVD_W'(a_q);
      end
      S_DIVB: begin
        div_req.start = 1'b1;
        div_dvd       = DVD_W'(b_mag);
      end
      S_TOPD: begin
        div_req.start   = 1'b1;
        div_req.long_op = 1'b1;
        div_dvd         = DVD_W'(prod) + DVD_W'(b_q[OW-1:0]);
      end
      default: begin
      end
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state_q)
      S_TRI: begin
        mul_x = MUL_W'(n_q);
        mul_y = MUL_W'(n_q - OW'(1));
      end
      S_TLO: begin
        mul_x = MUL_W'(tri_q[OW-1:0]);
        mul_y = MUL_W'(q_q);
      end
      S_THI: begin
        mul_x = MUL_W'(tri_q[TRI_W-1:OW]);
        mul_y = MUL_W'(q_q);
      end
      S_NB: begin
        mul_x = MUL_W'(n_q);
        mul_y = qb_q;
      end
      S_TOPM: begin
        mul_x = MUL_W'(a_q);
        mul_y = MUL_W'(n_q - OW'(1));
      end
      S_TN: begin
        mul_x = MUL_W'(top_q);
        mul_y = MUL_W'(n_q);
      end
      default: begin
      end
    endcase
  end

  // Accumulator: one add or subtract per cycle, sign from parity and offset.
  always_comb begin
    wide = WIDE_W'(prod);
    sub  = neg_q;
    unique case (state_q)
      S_THIR: wide = WIDE_W'(prod) << OW;
      S_NBR:  sub  = neg_q ^ bneg_q;
      S_SWAP: begin
        wide = WIDE_W'(top_q);
        sub  = !neg_q;
      end
      default: begin
      end
    endcase
    addend = wide[ACC_W-1:0];
    acc_d  = sub ? (acc_q - addend) : (acc_q + addend);
  end

  fsu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dvd),
    .divisor_i  (m_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  fsu_mul u_mul (
    .clk_i  (clk_i),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .prod_o (prod)
  );

  // Sequencer with its datapath and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
    end else begin
      // A taken result beat frees the output register unless a new sum
      // is loaded into it in the same cycle.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            a_q   <= slope_i;
            b_q   <= offset_i;
            m_q   <= divisor_i;
            n_q   <= count_i;
            acc_q <= '0;
            neg_q <= 1'b0;
            if ((divisor_i == '0) || (count_i == '0)) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_DIVA;
            end
          end
        end
        S_DIVA: state_q <= S_WDIVA;
        S_WDIVA: begin
          if (div_done) begin
            q_q     <= div_quot[OW-1:0];
            a_q     <= div_rem;
            state_q <= S_TRI;
          end
        end
        S_TRI: state_q <= S_TRIR;
        S_TRIR: begin
          tri_q   <= prod[TRI_W:1];
          state_q <= S_TLO;
        end
        S_TLO: state_q <= S_TLOR;
        S_TLOR: begin
          acc_q   <= acc_d;
          state_q <= S_THI;
        end
        S_THI: state_q <= S_THIR;
        S_THIR: begin
          acc_q   <= acc_d;
          state_q <= S_DIVB;
        end
        S_DIVB: state_q <= S_WDIVB;
        S_WDIVB: begin
          if (div_done) begin
            // Floor division: a negative offset with a remainder rounds down.
            bneg_q <= b_q[OW];
            if (b_q[OW] && (div_rem != '0)) begin
              qb_q <= div_quot[OW:0] + (OW+1)'(1);
              b_q  <= {1'b0, m_q - div_rem};
            end else if (b_q[OW]) begin
              qb_q <= div_quot[OW:0];
              b_q  <= '0;
            end else begin
              qb_q <= div_quot[OW:0];
              b_q  <= {1'b0, div_rem};
            end
            state_q <= S_NB;
          end
        end
        S_NB: state_q <= S_NBR;
        S_NBR: begin
          acc_q <= acc_d;
          if (a_q == '0) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_TOPM;
          end
        end
        S_TOPM: state_q <= S_TOPD;
        S_TOPD: state_q <= S_WTOP;
        S_WTOP: begin
          if (div_done) begin
            top_q   <= div_quot[OW-1:0];
            state_q <= S_TN;
          end
        end
        S_TN: state_q <= S_TNR;
        S_TNR: begin
          acc_q <= acc_d;
          if (top_q == '0) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_SWAP;
          end
        end
        S_SWAP: begin
          // Swap the roles of slope and divisor for the next level.
          acc_q   <= acc_d;
          neg_q   <= !neg_q;
          a_q     <= m_q;
          b_q     <= {1'b0, m_q - OW'(1) - b_q[OW-1:0]};
          m_q     <= a_q;
          n_q     <= top_q;
          state_q <= S_DIVA;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= acc_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign total_o     = out_q;

endmodule

FILE: hw/rtl/fsu_checker.sv
// ----------------------------------------------------------------------------
// fsu_checker
// Port-level checks of the floor sum unit, bound to every instance of it.
// ----------------------------------------------------------------------------
module fsu_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic signed [fsu_pkg::ACC_W-1:0]  total_o
);
  import fsu_pkg::*;

  // A result beat that is stalled keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(total_o))
    else $error("stalled result beat changed or vanished");

  // Once a request beat is taken the unit is busy in the next cycle.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken but unit not busy");

  // A new result only appears at the end of a request being worked on.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");

endmodule

bind floor_sum_unit fsu_checker u_fsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .total_o     (total_o)
);

FILE: tb/tb_floor_sum_unit.sv
// ----------------------------------------------------------------------------
// tb_floor_sum_unit
// Self-checking bench for the floor sum unit. Request beats go in through the
// valid/stall channel, and an in-bench predictor computes each expected sum by
// the Euclid-like reduction. Every result beat is compared in order against
// the oldest expected sum. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_floor_sum_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fsu_pkg::*;

  localparam logic [OW-1:0]        OPND_MAX = '1;
  localparam logic signed [OW:0]   OFFS_MAX = {1'b0, {OW{1'b1}}};
  localparam logic signed [OW:0]   OFFS_MIN = {1'b1, {OW{1'b0}}};

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic        [OW-1:0]     slope_i     = '0;
  logic signed [OW:0]       offset_i    = '0;
  logic        [OW-1:0]     divisor_i   = '0;
  logic        [OW-1:0]     count_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [ACC_W-1:0]  total_o;

  // Sums still owed by the unit, oldest first.
  logic [ACC_W-1:0] sum_queue[$];
  int               fail_count = 0;
  bit               idle_en    = 1'b1;
  int unsigned      stall_left = 0;

  floor_sum_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .slope_i     (slope_i),
    .offset_i    (offset_i),
    .divisor_i   (divisor_i),
    .count_i     (count_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .total_o     (total_o)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sum of floor((a*i + b) / m) for i below n, reduced level by level. The
  // accumulator wraps modulo 2^64 just as the result does.
  function automatic logic [ACC_W-1:0] floor_sum_expect(input logic [OW-1:0] slope,
                                                        input logic signed [OW:0] offs,
                                                        input logic [OW-1:0] dvs,
                                                        input logic [OW-1:0] cnt);
    longint unsigned a, m, n, acc, tri_sum, q, top, old_a;
    longint          b, qb;
    bit              neg;
    a   = slope;
    b   = offs;
    m   = dvs;
    n   = cnt;
    acc = 0;
    neg = 1'b0;
    if (m == 0 || n == 0) return '0;
    while (n != 0) begin
      // Triangular term from the whole part of the slope.
      q       = a / m;
      tri_sum = ((n & 1) == 0) ? (n / 2) * (n - 1) : ((n - 1) / 2) * n;
      acc     = neg ? acc - tri_sum * q : acc + tri_sum * q;
      a       = a % m;
      // Floor division of the offset, so that it ends up in [0, m).
      if (b >= 0) qb = longint'($unsigned(b) / m);
      else qb = -longint'(($unsigned(-b) + m - 1) / m);
      acc = neg ? acc - n * $unsigned(qb) : acc + n * $unsigned(qb);
      b   = b - qb * longint'(m);
      if (a == 0) break;
      top = (a * (n - 1) + $unsigned(b)) / m;
      acc = neg ? acc - top * n : acc + top * n;
      if (top < 1) break;
      acc   = neg ? acc + top : acc - top;
      neg   = !neg;
      // Swap roles of slope and divisor for the next level.
      old_a = a;
      a     = m;
      b     = longint'(m - 1 - $unsigned(b));
      m     = old_a;
      n     = top;
    end
    return acc;
  endfunction

  // Sender gap: mostly none or short, now and then a long pause.
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [OW-1:0] pick_operand();
    logic [OW-1:0] v;
    int unsigned   r;
    r = $urandom_range(0, 19);
    v = OW'($urandom_range(0, 2**OW - 1));
    if (r == 0) v = '0;
    else if (r == 1) v = OPND_MAX;
    else if (r < 5) v = OW'($urandom_range(1, 16));
    else if (r < 7) v = OW'(1 << $urandom_range(0, OW - 1));
    return v;
  endfunction

  function automatic logic signed [OW:0] pick_offset();
    logic signed [OW:0] v;
    int unsigned        r;
    r = $urandom_range(0, 19);
    v = (OW+1)'($urandom_range(0, 2**(OW + 1) - 1));
    if (r == 0) v = OFFS_MIN;
    else if (r == 1) v = OFFS_MAX;
    else if (r == 2) v = (OW+1)'(-1);
    else if (r < 7) v = (OW+1)'($signed($urandom_range(0, 64)) - 32);
    return v;
  endfunction

  // Zero divisors are kept rare so that most beats exercise the reduction.
  function automatic logic [OW-1:0] pick_divisor();
    logic [OW-1:0] v;
    v = pick_operand();
    if (v == 0 && $urandom_range(0, 3) != 0) v = OW'(1);
    return v;
  endfunction

  // Presents one request beat and holds it until the unit takes it.
  task automatic send_request(input logic [OW-1:0] slope, input logic signed [OW:0] offs,
                              input logic [OW-1:0] dvs, input logic [OW-1:0] cnt);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    slope_i    <= slope;
    offset_i   <= offs;
    divisor_i  <= dvs;
    count_i    <= cnt;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sum_queue.push_back(floor_sum_expect(slope, offs, dvs, cnt));
  endtask

  // Field extremes and the special cases: zero count, zero divisor, zero
  // slope, slope a multiple of the divisor, negative offsets, deep chains.
  task automatic test_directed();
    send_request(20'd5, 21'sd3, 20'd7, 20'd0);
    send_request(20'd5, 21'sd3, 20'd0, 20'd10);
    send_request(OPND_MAX, OFFS_MIN, 20'd0, OPND_MAX);
    send_request(20'd0, 21'sd0, 20'd1, 20'd1);
    send_request(OPND_MAX, OFFS_MAX, 20'd1, OPND_MAX);
    send_request(20'd0, OFFS_MIN, 20'd1, OPND_MAX);
    send_request(OPND_MAX, OFFS_MIN, OPND_MAX, OPND_MAX);
    send_request(OPND_MAX, OFFS_MAX, OPND_MAX, OPND_MAX);
    send_request(20'd832040, 21'sd0, 20'd514229, OPND_MAX);
    send_request(20'd514229, OFFS_MIN, 20'd832040, OPND_MAX);
    send_request(20'd7, -21'sd1, 20'd7, 20'd100);
    send_request(20'd3, -21'sd5, 20'd7, 20'd50);
    send_request(20'd1, 21'sd0, OPND_MAX, OPND_MAX);
    send_request(OPND_MAX, 21'sd0, 20'd1, 20'd1);
    send_request(20'd1, -21'sd1, 20'd2, 20'd2);
    send_request(20'd12345, 21'sd678, 20'd910, 20'd1);
    send_request(20'd0, 21'sd5, 20'd3, OPND_MAX);
    send_request(20'd2, OFFS_MAX, 20'd3, OPND_MAX);
    send_request(OPND_MAX - 20'd1, -21'sd1, OPND_MAX, OPND_MAX);
    send_request(20'd4096, -21'sd4097, 20'd4096, 20'd3);
  endtask

  // Operands drawn from mixed classes: extremes, small values, powers of two.
  task automatic test_random_mix(input int unsigned beats);
    repeat (beats) send_request(pick_operand(), pick_offset(), pick_divisor(), pick_operand());
  endtask

  // Slope near the golden ratio of the divisor gives the longest Euclid chains.
  task automatic test_deep_chains(input int unsigned beats);
    logic [OW-1:0] dvs, slope;
    repeat (beats) begin
      dvs   = OW'($urandom_range(2, 2**OW - 1));
      slope = OW'(((dvs * 633) >> 10) + $urandom_range(0, 3));
      send_request(slope, pick_offset(), dvs, pick_operand());
    end
  endtask

  // No gaps and no stalls, so beats follow each other as fast as allowed.
  task automatic test_back_to_back(input int unsigned beats);
    idle_en = 1'b0;
    test_random_mix(beats);
    idle_en = 1'b1;
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk_i) begin
    logic [ACC_W-1:0] want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (sum_queue.size() == 0) begin
        $error("total: no sum expected, got %0d", total_o);
        fail_count++;
      end else begin
        want = sum_queue.pop_front();
        if (total_o !== want) begin
          $error("total: expected %0d, got %0d", $signed(want), total_o);
          fail_count++;
        end
      end
    end
    // Alternate stalled and free stretches of random length.
    if (!idle_en || !rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
    end else if (!out_stall_i) begin
      out_stall_i <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 300)
                                                : $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
      stall_left = ($urandom_range(0, 6) == 0) ? $urandom_range(50, 400)
                                                : $urandom_range(0, 8);
    end
  end

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix(440);
    test_back_to_back(40);
    test_deep_chains(120);
    in_valid_i <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Watchdog: about four times the slowest correct run of some 620 beats.
  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/fsu_pkg.sv
hw/rtl/fsu_div.sv
hw/rtl/fsu_mul.sv
hw/rtl/floor_sum_unit.sv
hw/rtl/fsu_checker.sv
tb/tb_floor_sum_unit.sv
